>>> rtl/core/pwmenc_pkg.sv
// Shared types and constants for the PWM encoder multi-turn angle block.
`default_nettype none

package pwmenc_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 19;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_THRESHOLD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_PER_COUNT = 1'd1;

    localparam logic [15:0] WRAP_THRESHOLD_RESET  = 16'd819;
    localparam logic [18:0] ANGLE_PER_COUNT_RESET = 19'd402;

    // Two pi in Q24, rounded half up to the angle format at elaboration
    localparam longint TWO_PI_Q24 = 64'sd105414357;

    typedef struct packed {
        logic pwm_level;
        logic zero_request;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [15:0] turns;
        logic        [15:0] pulse_len;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/pwm_encoder_multiturn_angle.sv
// PWM absolute encoder pulse timer with multi-turn unwrap and angle output.
//
// Usage: one sampled PWM line level per sample transfer (sample_valid /
// sample_stall). The block times each high pulse; on a falling edge the pulse
// length is the raw count, a jump larger than wrap_threshold moves the signed
// turn counter, and a result (angle, turns, pulse_len) is sent on the result
// channel. The first pulse after reset only seeds the previous count.
// zero_request makes the current angle the zero reference; a result of the
// same sample already reads zero.
// Throughput: one sample per cycle while sample_stall is low. A result passes
// the front logic and register, the multiplier stage and the output register.
// The multiplier stage sits between the front register and the output
// register; the angle sum and zero subtraction feed the output register.
// When the receiver stalls, the result holds, and the two inner stages keep
// filling; sample_stall rises only when both inner stages are full, the
// second one holds a result and the output is stalled.
// Reset clears all state: pulse timer, turn counter, zero reference and the
// configuration registers (wrap_threshold 819, angle_per_count 402).
`default_nettype none

module pwm_encoder_multiturn_angle #(
    parameter int PULSE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     sample_valid,
    output logic                                    sample_stall,
    input  wire  pwmenc_pkg::sample_t               sample,
    output logic                                    result_valid,
    input  wire                                     result_stall,
    output pwmenc_pkg::result_t                     result,
    input  wire                                     cfg_write,
    input  wire  [pwmenc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [pwmenc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam longint TWO_PI_Q =
        (((pwmenc_pkg::TWO_PI_Q24 * 2) >>> (24 - FRAC_BITS)) + 1) >>> 1;
    localparam int TP_W  = $clog2(TWO_PI_Q + 1) + 1;
    localparam int PT_W  = 16 + TP_W;
    localparam int PR_W  = 35;
    localparam int SUM_W = ((PT_W > PR_W + 1) ? PT_W : PR_W + 1) + 1;
    localparam logic signed [TP_W-1:0]  TWO_PI_S = TP_W'(TWO_PI_Q);
    localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN  = SUM_W'(-64'sd2147483648);
    localparam logic signed [32:0]      DIF_MAX  = 33'(64'sd2147483647);
    localparam logic signed [32:0]      DIF_MIN  = 33'(-64'sd2147483648);
    localparam logic [PULSE_BITS-1:0]   TICK_MAX = '1;

    // Configuration
    logic [15:0] wrap_threshold_reg;
    logic [18:0] angle_per_count_reg;

    // Front state
    logic                  level_before_reg, level_before_next;
    logic [PULSE_BITS-1:0] tick_reg, tick_next;
    logic [15:0]           count_before_reg, count_before_next;
    logic                  seeded_reg, seeded_next;
    logic [15:0]           turn_reg, turn_next;

    // Stage 1
    logic        v1_reg, fall1_reg, emit1_reg, zreq1_reg;
    logic [15:0] raw1_reg, turns1_reg;
    // Stage 2
    logic                   v2_reg, fall2_reg, emit2_reg, zreq2_reg;
    logic [15:0]            raw2_reg, turns2_reg;
    logic signed [PT_W-1:0] pt2_reg;
    logic [PR_W-1:0]        pr2_reg;

    // Back state
    logic signed [31:0] last_angle_reg, last_angle_next;
    logic signed [31:0] zero_angle_reg, zero_angle_next;

    logic        result_valid_reg;
    pwmenc_pkg::result_t result_reg;

    logic en_out, consume2, en2, en1, accept;
    logic fall, emit;
    logic [15:0] raw;
    logic signed [16:0] delta, mag;
    logic signed [PT_W-1:0]  pt_next;
    logic [PR_W-1:0]         pr_next;
    logic signed [SUM_W-1:0] sum;
    logic signed [31:0]      abs_angle;
    logic signed [32:0]      dif;
    logic signed [31:0]      angle_out;

    // Stage handshakes
    assign en_out       = !result_valid_reg || !result_stall;
    assign consume2     = v2_reg && (!emit2_reg || en_out);
    assign en2          = !v2_reg || consume2;
    assign en1          = !v1_reg || en2;
    assign sample_stall = !en1;
    assign accept       = sample_valid && en1;

    // Front logic: pulse timer and turn counter
    always_comb
    begin
        level_before_next = sample.pwm_level;
        tick_next         = tick_reg;
        count_before_next = count_before_reg;
        seeded_next       = seeded_reg;
        turn_next         = turn_reg;
        fall              = 1'b0;
        emit              = 1'b0;
        raw               = (32'(tick_reg) > 32'hFFFF) ? 16'hFFFF : 16'(tick_reg);
        delta             = signed'({1'b0, raw}) - signed'({1'b0, count_before_reg});
        mag               = (delta < 0) ? -delta : delta;
        if (sample.pwm_level)
        begin
            if (!level_before_reg)
                tick_next = PULSE_BITS'(1);
            else if (tick_reg != TICK_MAX)
                tick_next = tick_reg + PULSE_BITS'(1);
        end
        else if (level_before_reg)
        begin
            fall = 1'b1;
            if (seeded_reg)
            begin
                emit = 1'b1;
                if (mag > signed'({1'b0, wrap_threshold_reg}))
                begin
                    if (delta > 0)
                        turn_next = turn_reg - 16'd1;
                    else
                        turn_next = turn_reg + 16'd1;
                end
            end
            seeded_next       = 1'b1;
            count_before_next = raw;
        end
    end

    // Multiplier stage inputs
    assign pt_next = signed'(turns1_reg) * TWO_PI_S;
    assign pr_next = PR_W'(raw1_reg) * PR_W'(angle_per_count_reg);

    // Angle sum, zero reference and output saturation
    always_comb
    begin
        sum = SUM_W'(pt2_reg) + SUM_W'(signed'({1'b0, pr2_reg}));
        if (sum > SUM_MAX)
            abs_angle = 32'sh7FFFFFFF;
        else if (sum < SUM_MIN)
            abs_angle = 32'sh80000000;
        else
            abs_angle = 32'(sum);
        last_angle_next = fall2_reg ? abs_angle : last_angle_reg;
        zero_angle_next = zreq2_reg ? last_angle_next : zero_angle_reg;
        dif = 33'(last_angle_next) - 33'(zero_angle_next);
        if (dif > DIF_MAX)
            angle_out = 32'sh7FFFFFFF;
        else if (dif < DIF_MIN)
            angle_out = 32'sh80000000;
        else
            angle_out = 32'(dif);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_threshold_reg  <= pwmenc_pkg::WRAP_THRESHOLD_RESET;
            angle_per_count_reg <= pwmenc_pkg::ANGLE_PER_COUNT_RESET;
            level_before_reg    <= 1'b0;
            tick_reg            <= '0;
            count_before_reg    <= '0;
            seeded_reg          <= 1'b0;
            turn_reg            <= '0;
            v1_reg              <= 1'b0;
            v2_reg              <= 1'b0;
            last_angle_reg      <= '0;
            zero_angle_reg      <= '0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pwmenc_pkg::CFG_WRAP_THRESHOLD:
                        wrap_threshold_reg <= cfg_data[15:0];
                    pwmenc_pkg::CFG_ANGLE_PER_COUNT:
                        angle_per_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                level_before_reg <= level_before_next;
                tick_reg         <= tick_next;
                count_before_reg <= count_before_next;
                seeded_reg       <= seeded_next;
                turn_reg         <= turn_next;
            end
            if (en1)
                v1_reg <= sample_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (consume2)
            begin
                last_angle_reg <= last_angle_next;
                zero_angle_reg <= zero_angle_next;
            end
            if (en_out)
                result_valid_reg <= v2_reg && emit2_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fall1_reg  <= fall;
            emit1_reg  <= emit;
            zreq1_reg  <= sample.zero_request;
            raw1_reg   <= raw;
            turns1_reg <= turn_next;
        end
        if (en2 && v1_reg)
        begin
            fall2_reg  <= fall1_reg;
            emit2_reg  <= emit1_reg;
            zreq2_reg  <= zreq1_reg;
            raw2_reg   <= raw1_reg;
            turns2_reg <= turns1_reg;
            pt2_reg    <= pt_next;
            pr2_reg    <= pr_next;
        end
        if (en_out && v2_reg && emit2_reg)
        begin
            result_reg.angle     <= angle_out;
            result_reg.turns     <= signed'(turns2_reg);
            result_reg.pulse_len <= raw2_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/pwmenc_checker.sv
// Port-level checks for the PWM encoder multi-turn angle block, with bind.
`default_nettype none

module pwmenc_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       sample_stall,
    input wire                       result_valid,
    input wire                       result_stall,
    input wire pwmenc_pkg::result_t  result
);

    // A stalled result holds until its transfer
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Every result follows at least one high tick
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pulse_len != 16'd0)
        else $error("result with zero pulse length");

    // With the output register empty the pipeline always drains
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("sample stalled with empty output");

endmodule

bind pwm_encoder_multiturn_angle pwmenc_checker u_pwmenc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
